// ===== design/lsff_pkg.sv =====
package lsff_pkg;

   localparam int CoordW    = 16;
   localparam int HtW       = 17;
   localparam int ExpW      = 16;
   localparam int OutW      = 17;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 17;
   localparam int FracW     = 16;
   localparam int RootSteps = 17;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_START_X   = 3'd0,
      CSR_START_Y   = 3'd1,
      CSR_END_X     = 3'd2,
      CSR_END_Y     = 3'd3,
      CSR_HALF_THK  = 3'd4,
      CSR_SHAPE_EXP = 3'd5
   } csr_index_type;

   typedef logic [FracW-1:0][31:0] root_table_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] bt;
      logic [63:0] rem;
      r   = '0;
      rem = x;
      bt  = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + bt) begin
            rem = rem - (r + bt);
            r   = (r >> 1) + bt;
         end else begin
            r = r >> 1;
         end
         bt = bt >> 2;
      end
      return r;
   endfunction

   // r[k] ~ 2^32 * 2^-(2^-(k+1)), Q0.32
   function automatic root_table_type build_roots();
      root_table_type tbl;
      logic [63:0]    r;
      r = isqrt64(64'h8000_0000_0000_0000);
      for (int k = 0; k < FracW; k++) begin
         tbl[k] = r[31:0];
         r      = isqrt64({r[31:0], 32'h0});
      end
      return tbl;
   endfunction

   localparam root_table_type Roots = build_roots();

endpackage

// ===== design/line_segment_falloff_field_unit.sv =====
// Line segment falloff field, fully pipelined.
// Request channel: start with req_pos_x / req_pos_y (Q0.16). A request is
// taken on every clock edge with start high; busy is held low, so a new
// position may be issued every cycle.
// Response channel: rsp_valid pulses for one cycle with rsp_field_value and
// rsp_distance (Q1.16, 65536 = 1.0). Responses are returned in request
// order. The receiver cannot stall; nothing is buffered.
// Throughput: one position per cycle. The pipeline is a chain of
// bit-per-stage units: segment parameter divide (16), square root (17),
// falloff divide (16), log by squaring (16) and power by root table (16),
// plus multiply and setup stages.
// CSR channel: csr_valid / csr_ready (ready always high), csr_index selects
// start_x, start_y, end_x, end_y, half_thickness, shaper_exponent (0..5);
// other indexes are ignored. Write only while no request is in flight.
// Reset (synchronous) empties the pipeline and restores the register
// defaults: start (0,0), end (65535,65535), half_thickness 8192,
// shaper_exponent 4096 (1.0).
module line_segment_falloff_field_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [lsff_pkg::CoordW-1:0]    req_pos_x,
   input  logic [lsff_pkg::CoordW-1:0]    req_pos_y,
   output logic                           rsp_valid,
   output logic [lsff_pkg::OutW-1:0]      rsp_field_value,
   output logic [lsff_pkg::OutW-1:0]      rsp_distance,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lsff_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [lsff_pkg::CsrDataW-1:0]  csr_wdata
);
   import lsff_pkg::*;

   logic [CoordW-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic [HtW-1:0]    half_thk_ff;
   logic [ExpW-1:0]   shape_exp_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         end_x_ff     <= 16'hFFFF;
         end_y_ff     <= 16'hFFFF;
         half_thk_ff  <= 17'd8192;
         shape_exp_ff <= 16'd4096;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_START_X:   start_x_ff   <= csr_wdata[CoordW-1:0];
            CSR_START_Y:   start_y_ff   <= csr_wdata[CoordW-1:0];
            CSR_END_X:     end_x_ff     <= csr_wdata[CoordW-1:0];
            CSR_END_Y:     end_y_ff     <= csr_wdata[CoordW-1:0];
            CSR_HALF_THK:  half_thk_ff  <= csr_wdata[HtW-1:0];
            CSR_SHAPE_EXP: shape_exp_ff <= csr_wdata[ExpW-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: differences
   logic                     s1_valid_ff;
   logic signed [16:0]       s1_dx_ff, s1_dy_ff, s1_wx_ff, s1_wy_ff;
   logic [CoordW-1:0]        s1_px_ff, s1_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_dx_ff <= $signed({1'b0, end_x_ff}) - $signed({1'b0, start_x_ff});
      s1_dy_ff <= $signed({1'b0, end_y_ff}) - $signed({1'b0, start_y_ff});
      s1_wx_ff <= $signed({1'b0, req_pos_x}) - $signed({1'b0, start_x_ff});
      s1_wy_ff <= $signed({1'b0, req_pos_y}) - $signed({1'b0, start_y_ff});
      s1_px_ff <= req_pos_x;
      s1_py_ff <= req_pos_y;
   end

   // ---------------- stage 2: products
   logic                     s2_valid_ff;
   logic signed [33:0]       s2_dxx_ff, s2_dyy_ff, s2_wdx_ff, s2_wdy_ff;
   logic signed [16:0]       s2_dx_ff, s2_dy_ff;
   logic [CoordW-1:0]        s2_px_ff, s2_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_dxx_ff <= s1_dx_ff * s1_dx_ff;
      s2_dyy_ff <= s1_dy_ff * s1_dy_ff;
      s2_wdx_ff <= s1_wx_ff * s1_dx_ff;
      s2_wdy_ff <= s1_wy_ff * s1_dy_ff;
      s2_dx_ff  <= s1_dx_ff;
      s2_dy_ff  <= s1_dy_ff;
      s2_px_ff  <= s1_px_ff;
      s2_py_ff  <= s1_py_ff;
   end

   // ---------------- stage 3 + segment parameter divide
   logic                     d1_valid_ff [FracW+1];
   logic [33:0]              d1_rem_ff   [FracW+1];
   logic [FracW-1:0]         d1_q_ff     [FracW+1];
   logic [32:0]              d1_len2_ff  [FracW+1];
   logic signed [16:0]       d1_dx_ff    [FracW+1];
   logic signed [16:0]       d1_dy_ff    [FracW+1];
   logic [CoordW-1:0]        d1_px_ff    [FracW+1];
   logic [CoordW-1:0]        d1_py_ff    [FracW+1];
   logic                     d1_tzero_ff [FracW+1];
   logic                     d1_tfull_ff [FracW+1];

   logic [32:0]              s3_len2;
   logic signed [34:0]       s3_dot;
   logic                     s3_tzero, s3_tfull;

   always_comb begin
      s3_len2  = {1'b0, s2_dxx_ff[31:0]} + {1'b0, s2_dyy_ff[31:0]};
      s3_dot   = $signed({s2_wdx_ff[33], s2_wdx_ff}) + $signed({s2_wdy_ff[33], s2_wdy_ff});
      s3_tzero = s3_dot[34] | (s3_dot == '0);
      s3_tfull = ~s3_tzero & (s3_dot[33:0] >= {1'b0, s3_len2});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff[0] <= 1'b0;
      end else begin
         d1_valid_ff[0] <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      d1_rem_ff[0]   <= (s3_tzero | s3_tfull) ? '0 : s3_dot[33:0];
      d1_q_ff[0]     <= '0;
      d1_len2_ff[0]  <= s3_len2;
      d1_dx_ff[0]    <= s2_dx_ff;
      d1_dy_ff[0]    <= s2_dy_ff;
      d1_px_ff[0]    <= s2_px_ff;
      d1_py_ff[0]    <= s2_py_ff;
      d1_tzero_ff[0] <= s3_tzero;
      d1_tfull_ff[0] <= s3_tfull;
   end

   for (genvar g = 0; g < FracW; g++) begin : g_div1
      logic [33:0] sh;
      logic        ge;
      always_comb begin
         sh = {d1_rem_ff[g][32:0], 1'b0};
         ge = sh >= {1'b0, d1_len2_ff[g]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            d1_valid_ff[g+1] <= 1'b0;
         end else begin
            d1_valid_ff[g+1] <= d1_valid_ff[g];
         end
      end
      always_ff @(posedge clock) begin
         d1_rem_ff[g+1]   <= ge ? sh - {1'b0, d1_len2_ff[g]} : sh;
         d1_q_ff[g+1]     <= {d1_q_ff[g][FracW-2:0], ge};
         d1_len2_ff[g+1]  <= d1_len2_ff[g];
         d1_dx_ff[g+1]    <= d1_dx_ff[g];
         d1_dy_ff[g+1]    <= d1_dy_ff[g];
         d1_px_ff[g+1]    <= d1_px_ff[g];
         d1_py_ff[g+1]    <= d1_py_ff[g];
         d1_tzero_ff[g+1] <= d1_tzero_ff[g];
         d1_tfull_ff[g+1] <= d1_tfull_ff[g];
      end
   end

   // ---------------- offset products
   logic                     m_valid_ff;
   logic signed [34:0]       m_prodx_ff, m_prody_ff;
   logic [CoordW-1:0]        m_px_ff, m_py_ff;
   logic [16:0]              m_t;

   always_comb begin
      if (d1_tzero_ff[FracW]) begin
         m_t = '0;
      end else if (d1_tfull_ff[FracW]) begin
         m_t = 17'h10000;
      end else begin
         m_t = {1'b0, d1_q_ff[FracW]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= d1_valid_ff[FracW];
      end
   end

   always_ff @(posedge clock) begin
      m_prodx_ff <= d1_dx_ff[FracW] * $signed({1'b0, m_t});
      m_prody_ff <= d1_dy_ff[FracW] * $signed({1'b0, m_t});
      m_px_ff    <= d1_px_ff[FracW];
      m_py_ff    <= d1_py_ff[FracW];
   end

   // ---------------- rounding, closest point, error vector
   logic                     r_valid_ff;
   logic signed [17:0]       r_ex_ff, r_ey_ff;
   logic [34:0]              r_magx, r_magy;
   logic [32:0]              r_rndx, r_rndy;
   logic signed [18:0]       r_offx, r_offy, r_cx, r_cy, r_ex, r_ey;

   always_comb begin
      r_magx = m_prodx_ff[34] ? 35'(-m_prodx_ff) : 35'(m_prodx_ff);
      r_magy = m_prody_ff[34] ? 35'(-m_prody_ff) : 35'(m_prody_ff);
      r_rndx = r_magx[32:0] + 33'd32768;
      r_rndy = r_magy[32:0] + 33'd32768;
      r_offx = m_prodx_ff[34] ? -$signed({2'b0, r_rndx[32:16]})
                              :  $signed({2'b0, r_rndx[32:16]});
      r_offy = m_prody_ff[34] ? -$signed({2'b0, r_rndy[32:16]})
                              :  $signed({2'b0, r_rndy[32:16]});
      r_cx   = $signed({3'b0, start_x_ff}) + r_offx;
      r_cy   = $signed({3'b0, start_y_ff}) + r_offy;
      r_ex   = $signed({3'b0, m_px_ff}) - r_cx;
      r_ey   = $signed({3'b0, m_py_ff}) - r_cy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      r_ex_ff <= r_ex[17:0];
      r_ey_ff <= r_ey[17:0];
   end

   // ---------------- squares
   logic                     q_valid_ff;
   logic [31:0]              q_sqx_ff, q_sqy_ff;
   logic signed [35:0]       q_sqx, q_sqy;

   always_comb begin
      q_sqx = r_ex_ff * r_ex_ff;
      q_sqy = r_ey_ff * r_ey_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_sqx_ff <= q_sqx[31:0];
      q_sqy_ff <= q_sqy[31:0];
   end

   // ---------------- square root, one result bit per stage
   logic                     sq_valid_ff [RootSteps+1];
   logic [33:0]              sq_rad_ff   [RootSteps+1];
   logic [18:0]              sq_rem_ff   [RootSteps+1];
   logic [16:0]              sq_root_ff  [RootSteps+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else begin
         sq_valid_ff[0] <= q_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_rad_ff[0]  <= {2'b0, q_sqx_ff} + {2'b0, q_sqy_ff};
      sq_rem_ff[0]  <= '0;
      sq_root_ff[0] <= '0;
   end

   for (genvar i = 0; i < RootSteps; i++) begin : g_sqrt
      logic [20:0] remsh;
      logic [20:0] trial;
      logic        ge;
      always_comb begin
         remsh = {sq_rem_ff[i], sq_rad_ff[i][33-2*i -: 2]};
         trial = {2'b0, sq_root_ff[i], 2'b01};
         ge    = remsh >= trial;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[i+1] <= 1'b0;
         end else begin
            sq_valid_ff[i+1] <= sq_valid_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         sq_rad_ff[i+1]  <= sq_rad_ff[i];
         sq_rem_ff[i+1]  <= ge ? 19'(remsh - trial) : remsh[18:0];
         sq_root_ff[i+1] <= {sq_root_ff[i][15:0], ge};
      end
   end

   // ---------------- falloff map divide
   logic                     vd_valid_ff [FracW+1];
   logic [HtW-1:0]           vd_rem_ff   [FracW+1];
   logic [FracW-1:0]         vd_q_ff     [FracW+1];
   logic [OutW-1:0]          vd_dist_ff  [FracW+1];
   logic                     vd_one_ff   [FracW+1];
   logic                     vd_zero_ff  [FracW+1];

   logic [OutW-1:0]          v_dist;
   logic                     v_one, v_zero;

   always_comb begin
      v_dist = (sq_root_ff[RootSteps] > 17'h10000) ? 17'h10000 : sq_root_ff[RootSteps];
      v_one  = (half_thk_ff == '0) | (v_dist == '0);
      v_zero = ~v_one & (v_dist >= half_thk_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_valid_ff[0] <= 1'b0;
      end else begin
         vd_valid_ff[0] <= sq_valid_ff[RootSteps];
      end
   end

   always_ff @(posedge clock) begin
      vd_rem_ff[0]  <= (v_one | v_zero) ? '0 : half_thk_ff - v_dist;
      vd_q_ff[0]    <= '0;
      vd_dist_ff[0] <= v_dist;
      vd_one_ff[0]  <= v_one;
      vd_zero_ff[0] <= v_zero;
   end

   for (genvar g = 0; g < FracW; g++) begin : g_div2
      logic [HtW:0] sh;
      logic         ge;
      always_comb begin
         sh = {vd_rem_ff[g], 1'b0};
         ge = sh >= {1'b0, half_thk_ff};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vd_valid_ff[g+1] <= 1'b0;
         end else begin
            vd_valid_ff[g+1] <= vd_valid_ff[g];
         end
      end
      always_ff @(posedge clock) begin
         vd_rem_ff[g+1]  <= ge ? HtW'(sh - {1'b0, half_thk_ff}) : sh[HtW-1:0];
         vd_q_ff[g+1]    <= {vd_q_ff[g][FracW-2:0], ge};
         vd_dist_ff[g+1] <= vd_dist_ff[g];
         vd_one_ff[g+1]  <= vd_one_ff[g];
         vd_zero_ff[g+1] <= vd_zero_ff[g];
      end
   end

   // ---------------- log2 by repeated squaring
   logic                     lg_valid_ff [FracW+1];
   logic [30:0]              lg_z_ff     [FracW+1];
   logic [FracW-1:0]         lg_frac_ff  [FracW+1];
   logic [3:0]               lg_p_ff     [FracW+1];
   logic [OutW-1:0]          lg_dist_ff  [FracW+1];
   logic                     lg_one_ff   [FracW+1];
   logic                     lg_zero_ff  [FracW+1];

   logic [FracW-1:0]         l_v;
   logic [3:0]               l_p;
   logic                     l_one, l_zero;

   always_comb begin
      l_v = vd_q_ff[FracW];
      l_p = '0;
      for (int j = 0; j < FracW; j++) begin
         if (l_v[j]) begin
            l_p = 4'(j);
         end
      end
      l_one  = (shape_exp_ff == '0) | vd_one_ff[FracW];
      l_zero = ~l_one & (vd_zero_ff[FracW] | (l_v == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_valid_ff[0] <= 1'b0;
      end else begin
         lg_valid_ff[0] <= vd_valid_ff[FracW];
      end
   end

   always_ff @(posedge clock) begin
      lg_z_ff[0]    <= {l_v, 15'b0} << (4'd15 - l_p);
      lg_frac_ff[0] <= '0;
      lg_p_ff[0]    <= l_p;
      lg_dist_ff[0] <= vd_dist_ff[FracW];
      lg_one_ff[0]  <= l_one;
      lg_zero_ff[0] <= l_zero;
   end

   for (genvar i = 0; i < FracW; i++) begin : g_log
      logic [61:0] sqr;
      logic [31:0] zz;
      always_comb begin
         sqr = lg_z_ff[i] * lg_z_ff[i];
         zz  = sqr[61:30];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            lg_valid_ff[i+1] <= 1'b0;
         end else begin
            lg_valid_ff[i+1] <= lg_valid_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         lg_z_ff[i+1]    <= zz[31] ? zz[31:1] : zz[30:0];
         lg_frac_ff[i+1] <= {lg_frac_ff[i][FracW-2:0], zz[31]};
         lg_p_ff[i+1]    <= lg_p_ff[i];
         lg_dist_ff[i+1] <= lg_dist_ff[i];
         lg_one_ff[i+1]  <= lg_one_ff[i];
         lg_zero_ff[i+1] <= lg_zero_ff[i];
      end
   end

   // ---------------- scale by exponent
   logic                     y_valid_ff;
   logic [37:0]              y_prod_ff;
   logic [OutW-1:0]          y_dist_ff;
   logic                     y_one_ff, y_zero_ff;
   logic [20:0]              y_lg;

   always_comb begin
      y_lg = {5'd16 - {1'b0, lg_p_ff[FracW]}, 16'b0} - {5'b0, lg_frac_ff[FracW]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_valid_ff <= 1'b0;
      end else begin
         y_valid_ff <= lg_valid_ff[FracW];
      end
   end

   always_ff @(posedge clock) begin
      y_prod_ff <= 38'(y_lg) * 38'(shape_exp_ff) + 38'd2048;
      y_dist_ff <= lg_dist_ff[FracW];
      y_one_ff  <= lg_one_ff[FracW];
      y_zero_ff <= lg_zero_ff[FracW] | 1'b0;
   end

   // ---------------- 2^-f by root table
   logic                     pw_valid_ff [FracW+1];
   logic [32:0]              pw_e_ff     [FracW+1];
   logic [FracW-1:0]         pw_f_ff     [FracW+1];
   logic [4:0]               pw_n_ff     [FracW+1];
   logic [OutW-1:0]          pw_dist_ff  [FracW+1];
   logic                     pw_one_ff   [FracW+1];
   logic                     pw_zero_ff  [FracW+1];

   logic [25:0]              z_y;
   logic                     z_deep;

   always_comb begin
      z_y    = y_prod_ff[37:12];
      z_deep = z_y[25:16] >= 10'd17;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_valid_ff[0] <= 1'b0;
      end else begin
         pw_valid_ff[0] <= y_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      pw_e_ff[0]    <= 33'h1_0000_0000;
      pw_f_ff[0]    <= z_y[15:0];
      pw_n_ff[0]    <= z_y[20:16];
      pw_dist_ff[0] <= y_dist_ff;
      pw_one_ff[0]  <= y_one_ff;
      pw_zero_ff[0] <= ~y_one_ff & (y_zero_ff | z_deep);
   end

   for (genvar i = 0; i < FracW; i++) begin : g_pow
      logic [64:0] prod;
      always_comb begin
         prod = pw_e_ff[i] * Roots[i];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            pw_valid_ff[i+1] <= 1'b0;
         end else begin
            pw_valid_ff[i+1] <= pw_valid_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         pw_e_ff[i+1]    <= pw_f_ff[i][FracW-1-i] ? prod[64:32] : pw_e_ff[i];
         pw_f_ff[i+1]    <= pw_f_ff[i];
         pw_n_ff[i+1]    <= pw_n_ff[i];
         pw_dist_ff[i+1] <= pw_dist_ff[i];
         pw_one_ff[i+1]  <= pw_one_ff[i];
         pw_zero_ff[i+1] <= pw_zero_ff[i];
      end
   end

   // ---------------- final rounding and response register
   logic                     rsp_valid_ff;
   logic [OutW-1:0]          rsp_value_ff, rsp_dist_ff;
   logic [33:0]              f_sum;
   logic [33:0]              f_rnd;
   logic [OutW-1:0]          f_val;

   always_comb begin
      f_sum = {1'b0, pw_e_ff[FracW]} + (34'd1 << (6'd15 + {1'b0, pw_n_ff[FracW]}));
      f_rnd = f_sum >> (6'd16 + {1'b0, pw_n_ff[FracW]});
      if (pw_one_ff[FracW]) begin
         f_val = 17'h10000;
      end else if (pw_zero_ff[FracW]) begin
         f_val = '0;
      end else if (f_rnd > 34'h10000) begin
         f_val = 17'h10000;
      end else begin
         f_val = f_rnd[OutW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pw_valid_ff[FracW];
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= f_val;
      rsp_dist_ff  <= pw_dist_ff[FracW];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_value = rsp_value_ff;
   assign rsp_distance    = rsp_dist_ff;

endmodule

// ===== test/tb_line_segment_falloff_field_unit.sv =====
`timescale 1ns / 1ps

module tb_line_segment_falloff_field_unit;
   import lsff_pkg::*;

   localparam int PipeLatency = 93;
   localparam int StallLimit  = 20000;
   localparam int NumRandom   = 1500;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CoordW-1:0]   req_pos_x;
   logic [CoordW-1:0]   req_pos_y;
   logic                rsp_valid;
   logic [OutW-1:0]     rsp_field_value;
   logic [OutW-1:0]     rsp_distance;
   logic                csr_valid;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   line_segment_falloff_field_unit u_top (.*);

   typedef struct packed {
      logic [OutW-1:0] field_value;
      logic [OutW-1:0] distance;
   } falloff_type;

   typedef struct {
      logic [CoordW-1:0] px;
      logic [CoordW-1:0] py;
      logic              known;
      falloff_type       res;
   } vector_type;

   logic [15:0] seg_ax, seg_ay, seg_bx, seg_by, shape_exp;
   logic [16:0] half_thk;

   falloff_type falloff_q[$];
   int          fail_count;
   int          idle_cycles;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, bt;
      r  = 0;
      bt = 64'h4000_0000_0000_0000;
      while (bt > x) bt = bt >> 2;
      while (bt != 0) begin
         if (x >= r + bt) begin
            x = x - (r + bt);
            r = (r >> 1) + bt;
         end else begin
            r = r >> 1;
         end
         bt = bt >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned power_shape(input longint unsigned v,
                                                   input longint unsigned s);
      int unsigned     p;
      longint unsigned z, frac, lg, y, n, f, e, r;
      p    = 0;
      frac = 0;
      while (p < 15 && (v >> (p + 1)) != 0) p++;
      z = (v << (15 - p)) << 15;
      for (int i = 0; i < 16; i++) begin
         z = (z * z) >> 30;
         if (z >= (64'd1 << 31)) begin
            z    = z >> 1;
            frac = frac | (64'd1 << (15 - i));
         end
      end
      lg = ((64'd16 - p) << 16) - frac;
      y  = (lg * s + 2048) >> 12;
      n  = y >> 16;
      f  = y & 64'hFFFF;
      if (n >= 17) return 0;
      e = 64'd1 << 32;
      r = int_sqrt(64'd1 << 63);
      for (int i = 1; i <= 16; i++) begin
         if ((f >> (16 - i)) & 1) e = (e * r) >> 32;
         r = int_sqrt(r << 32);
      end
      e = (e + (64'd1 << (15 + n))) >> (16 + n);
      return (e > 65536) ? 65536 : e;
   endfunction

   function automatic longint round_step(input longint d, input longint unsigned t);
      longint          prod, q;
      longint unsigned mag;
      prod = d * longint'(t);
      mag  = (prod < 0) ? longint'(-prod) : prod;
      q    = longint'((mag + 32768) >> 16);
      return (prod < 0) ? -q : q;
   endfunction

   function automatic falloff_type predict_falloff(input logic [15:0] px_in,
                                                   input logic [15:0] py_in);
      longint          px, py, ax, ay, dx, dy, wx, wy, dot, cx, cy, ex, ey;
      longint unsigned len2, t, seg_dist, v, val;
      falloff_type     res;
      px   = px_in;
      py   = py_in;
      ax   = seg_ax;
      ay   = seg_ay;
      dx   = longint'(seg_bx) - ax;
      dy   = longint'(seg_by) - ay;
      wx   = px - ax;
      wy   = py - ay;
      len2 = dx * dx + dy * dy;
      dot  = wx * dx + wy * dy;
      cx   = ax;
      cy   = ay;
      if (len2 != 0) begin
         if (dot <= 0) t = 0;
         else if (longint'(dot) >= longint'(len2)) t = 65536;
         else t = (longint'(dot) << 16) / len2;
         cx = ax + round_step(dx, t);
         cy = ay + round_step(dy, t);
      end
      ex       = px - cx;
      ey       = py - cy;
      seg_dist = int_sqrt(ex * ex + ey * ey);
      if (seg_dist > 65536) seg_dist = 65536;
      if (half_thk == 0) v = 65536;
      else if (seg_dist >= half_thk) v = 0;
      else v = ((longint'(half_thk) - seg_dist) << 16) / half_thk;
      if (shape_exp == 0) val = 65536;
      else if (v == 0) val = 0;
      else if (v >= 65536) val = 65536;
      else val = power_shape(v, shape_exp);
      res.field_value = val[OutW-1:0];
      res.distance    = seg_dist[OutW-1:0];
      return res;
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [16:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_START_X:   seg_ax    = data[15:0];
         CSR_START_Y:   seg_ay    = data[15:0];
         CSR_END_X:     seg_bx    = data[15:0];
         CSR_END_Y:     seg_by    = data[15:0];
         CSR_HALF_THK:  half_thk  = data;
         CSR_SHAPE_EXP: shape_exp = data[15:0];
         default: ;
      endcase
   endtask

   task automatic write_bad_index();
      csr_valid <= 1'b1;
      csr_index <= 3'(6 + $urandom_range(0, 1));
      csr_wdata <= 17'($urandom);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (falloff_q.size() != 0) @(negedge clock);
      repeat (PipeLatency + 5) @(negedge clock);
   endtask

   task automatic send_request(input logic [15:0] px, input logic [15:0] py,
                               input bit allow_gap);
      int gap;
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                           : $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      @(posedge clock);
      while (busy) @(posedge clock);
      falloff_q.push_back(predict_falloff(px, py));
      @(negedge clock);
   endtask

   task automatic random_phase(input int count);
      logic [15:0] px, py;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: begin
               px = 16'($urandom);
               py = 16'($urandom);
            end
            1: begin
               px = 16'(int'(seg_ax) + $urandom_range(0, 8000) - 4000);
               py = 16'(int'(seg_ay) + $urandom_range(0, 8000) - 4000);
            end
            default: begin
               px = 16'((int'(seg_ax) + int'(seg_bx)) / 2 + $urandom_range(0, 6000) - 3000);
               py = 16'((int'(seg_ay) + int'(seg_by)) / 2 + $urandom_range(0, 6000) - 3000);
            end
         endcase
         send_request(px, py, (i % 200) < 150);
      end
      start <= 1'b0;
   endtask

   vector_type directed_tbl[$];

   task automatic add_row(input logic [15:0] px, input logic [15:0] py, input bit known,
                          input logic [16:0] fv, input logic [16:0] dist_val);
      vector_type row;
      row.px              = px;
      row.py              = py;
      row.known           = known;
      row.res.field_value = fv;
      row.res.distance    = dist_val;
      directed_tbl.push_back(row);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (falloff_q.size() == 0) begin
               $error("unexpected response fv=%0d dist=%0d", rsp_field_value, rsp_distance);
               fail_count++;
            end else begin
               if (rsp_field_value !== falloff_q[0].field_value) begin
                  $error("field_value expected %0d actual %0d",
                         falloff_q[0].field_value, rsp_field_value);
                  fail_count++;
               end
               if (rsp_distance !== falloff_q[0].distance) begin
                  $error("distance expected %0d actual %0d",
                         falloff_q[0].distance, rsp_distance);
                  fail_count++;
               end
               void'(falloff_q.pop_front());
            end
         end
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      fail_count = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_pos_x  = '0;
      req_pos_y  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      seg_ax = 0; seg_ay = 0; seg_bx = 16'hFFFF; seg_by = 16'hFFFF;
      half_thk = 17'd8192; shape_exp = 16'd4096;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // on the default diagonal: distance 0, value 1.0; then off-diagonal points from predict_falloff
      add_row(16'h0000, 16'h0000, 1, 17'd65536, 17'd0);
      add_row(16'hFFFF, 16'hFFFF, 1, 17'd65536, 17'd0);
      add_row(16'h8000, 16'h8000, 1, 17'd65536, 17'd0);
      add_row(16'hFFFF, 16'h0000, 0, 0, 0);
      add_row(16'h0000, 16'hFFFF, 0, 0, 0);
      add_row(16'h1000, 16'h0800, 0, 0, 0);
      add_row(16'h5555, 16'hAAAA, 0, 0, 0);
      add_row(16'h0100, 16'h0000, 0, 0, 0);
      foreach (directed_tbl[i]) begin
         start     <= 1'b1;
         req_pos_x <= directed_tbl[i].px;
         req_pos_y <= directed_tbl[i].py;
         @(posedge clock);
         while (busy) @(posedge clock);
         falloff_q.push_back(directed_tbl[i].known ? directed_tbl[i].res
                             : predict_falloff(directed_tbl[i].px, directed_tbl[i].py));
         @(negedge clock);
      end
      start <= 1'b0;
      drain();

      // zero-length segment, zero exponent, bad index
      write_csr(CSR_END_X, 17'd0);
      write_csr(CSR_END_Y, 17'd0);
      write_csr(CSR_SHAPE_EXP, 17'd0);
      write_bad_index();
      add_row(16'hFFFF, 16'hFFFF, 1, 17'd65536, 17'd65536);
      add_row(16'h0000, 16'h0000, 1, 17'd65536, 17'd0);
      for (int i = directed_tbl.size() - 2; i < directed_tbl.size(); i++)
         send_request(directed_tbl[i].px, directed_tbl[i].py, 0);
      start <= 1'b0;
      drain();

      // max exponent, thickness 1.0, then zero thickness, then max thickness with exponent 1
      write_csr(CSR_SHAPE_EXP, 17'hFFFF);
      write_csr(CSR_HALF_THK, 17'd65536);
      send_request(16'h0000, 16'h0000, 0);
      send_request(16'h4000, 16'h0000, 0);
      send_request(16'hFFFF, 16'h0000, 0);
      start <= 1'b0;
      drain();
      write_csr(CSR_HALF_THK, 17'd0);
      send_request(16'h1234, 16'h4321, 0);
      start <= 1'b0;
      drain();
      write_csr(CSR_HALF_THK, 17'h1FFFF);
      write_csr(CSR_SHAPE_EXP, 17'd1);
      send_request(16'hFFFF, 16'h0000, 0);
      send_request(16'h0000, 16'hFFFF, 0);
      start <= 1'b0;
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_START_X, 17'($urandom));
         write_csr(CSR_START_Y, 17'($urandom));
         write_csr(CSR_END_X, (ph == 1) ? 17'hFFFF : 17'($urandom));
         write_csr(CSR_END_Y, (ph == 1) ? 17'd0 : 17'($urandom));
         write_csr(CSR_HALF_THK, (ph == 2) ? 17'd1 : 17'($urandom_range(1, 65536)));
         write_csr(CSR_SHAPE_EXP, (ph == 3) ? 17'hFFFF : 17'($urandom_range(1, 20000)));
         random_phase(NumRandom / 6);
         drain();
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
